// ===== src/bod_pkg.sv =====
`default_nettype none
package bod_pkg;

   // field widths
   localparam int unsigned CmdWidth   = 1;
   localparam int unsigned AddrWidth  = 15;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned BankWidth  = 2;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned PermWidth  = 24;
   localparam int unsigned SelWidth   = 3;
   localparam int unsigned NumBanks   = 4;

   // register port geometry
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrIdxWidth  = 3;

   typedef logic [ByteWidth-1:0]    byte_type;
   typedef logic [PermWidth-1:0]    perm_type;
   typedef logic [BankWidth-1:0]    bank_type;
   typedef logic [CountWidth-1:0]   count_type;
   typedef logic [AddrWidth-1:0]    addr_type;
   typedef logic [CsrAddrWidth-1:0] csr_addr_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   // item commands
   typedef enum logic [CmdWidth-1:0] {
      CMD_PORT_READ = 1'b0,
      CMD_FETCH     = 1'b1
   } cmd_type;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_INVERT0 = 3'd0,
      REG_INVERT1 = 3'd1,
      REG_INVERT2 = 3'd2,
      REG_INVERT3 = 3'd3,
      REG_PERM0   = 3'd4,
      REG_PERM1   = 3'd5,
      REG_PERM2   = 3'd6,
      REG_PERM3   = 3'd7
   } reg_idx_type;

   // reset values
   localparam byte_type  InvertReset0 = 8'hFC;
   localparam byte_type  InvertReset1 = 8'hF6;
   localparam byte_type  InvertReset2 = 8'h7D;
   localparam byte_type  InvertReset3 = 8'h77;
   localparam perm_type  PermReset0   = 24'd8153173;
   localparam perm_type  PermReset1   = 24'd3946901;
   localparam perm_type  PermReset2   = 24'd6450773;
   localparam perm_type  PermReset3   = 24'd2244501;
   localparam count_type CountReset   = 4'hA;
   localparam bank_type  BankReset    = 2'd2;

   // the counter selects a bank while it sits in 8..11
   localparam logic [1:0] BankWindow = 2'b10;

   // output bit k takes the source bit named by perm[3k+2:3k]
   function automatic byte_type permute_byte(input byte_type value, input perm_type perm);
      byte_type result;
      result = '0;
      for (int k = 0; k < ByteWidth; k++) begin
         result[k] = value[perm[SelWidth*k +: SelWidth]];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== src/bod_if.sv =====
`default_nettype none
interface bod_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [bod_pkg::AddrWidth-1:0] address;
   logic [bod_pkg::ByteWidth-1:0] raw_byte;

   modport source (output valid, output cmd, output address, output raw_byte, input ready);
   modport sink   (input valid, input cmd, input address, input raw_byte, output ready);
endinterface

interface bod_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bod_pkg::ByteWidth-1:0] data;
   logic [bod_pkg::BankWidth-1:0] bank;

   modport source (output valid, output data, output bank, input ready);
   modport sink   (input valid, input data, input bank, output ready);
endinterface
`default_nettype wire

// ===== src/banked_opcode_decrypt_unit.sv =====
`default_nettype none
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the receiver is ready; the result register refills while it drains.
// The XOR, bank mux and bit permutation sit between the input and result register.
// Reset (synchronous, active high): counter 10, bank 2, mask and permutation
// registers take their documented defaults, result register empties.
module banked_opcode_decrypt_unit (
   input  wire                          clock,
   input  wire                          reset,
   bod_req_if.sink                      req_bus,
   bod_rsp_if.source                    rsp_bus,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [bod_pkg::CsrAddrWidth-1:0] paddr,
   input  wire [bod_pkg::CsrDataWidth-1:0] pwdata,
   output logic [bod_pkg::CsrDataWidth-1:0] prdata,
   output logic                         pready
);
   import bod_pkg::*;

   byte_type    invert_ff [NumBanks];
   perm_type    perm_ff   [NumBanks];
   count_type   count_ff, count_in;
   bank_type    bank_ff, bank_in;
   logic        valid_ff;
   byte_type    data_ff, data_in;
   bank_type    rsp_bank_ff;
   logic        accept;
   logic        csr_write;
   reg_idx_type csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_idx   = reg_idx_type'(paddr[CsrAddrWidth-1 -: CsrIdxWidth]);

   // take a beat when the result register is empty or draining
   assign req_bus.ready = !valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // step the counter on port reads, decrypt on fetches
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      data_in  = '0;
      case (cmd_type'(req_bus.cmd))
         CMD_PORT_READ: begin
            count_in = req_bus.address[0] ? count_ff - 1'b1 : count_ff + 1'b1;
            if (count_in[CountWidth-1 -: 2] == BankWindow) begin
               bank_in = count_in[BankWidth-1:0];
            end
         end
         CMD_FETCH: begin
            data_in = permute_byte(req_bus.raw_byte ^ invert_ff[bank_ff], perm_ff[bank_ff]);
         end
         default: begin
            data_in = '0;
         end
      endcase
   end

   // hold state and the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
         bank_ff  <= BankReset;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            bank_ff  <= bank_in;
            valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         data_ff     <= data_in;
         rsp_bank_ff <= bank_in;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.data  = data_ff;
   assign rsp_bus.bank  = rsp_bank_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff[0] <= InvertReset0;
         invert_ff[1] <= InvertReset1;
         invert_ff[2] <= InvertReset2;
         invert_ff[3] <= InvertReset3;
         perm_ff[0]   <= PermReset0;
         perm_ff[1]   <= PermReset1;
         perm_ff[2]   <= PermReset2;
         perm_ff[3]   <= PermReset3;
      end else if (csr_write) begin
         case (csr_idx)
            REG_INVERT0: invert_ff[0] <= pwdata[ByteWidth-1:0];
            REG_INVERT1: invert_ff[1] <= pwdata[ByteWidth-1:0];
            REG_INVERT2: invert_ff[2] <= pwdata[ByteWidth-1:0];
            REG_INVERT3: invert_ff[3] <= pwdata[ByteWidth-1:0];
            REG_PERM0:   perm_ff[0]   <= pwdata[PermWidth-1:0];
            REG_PERM1:   perm_ff[1]   <= pwdata[PermWidth-1:0];
            REG_PERM2:   perm_ff[2]   <= pwdata[PermWidth-1:0];
            REG_PERM3:   perm_ff[3]   <= pwdata[PermWidth-1:0];
            default: ;
         endcase
      end
   end

   // read back configuration registers
   always_comb begin
      case (csr_idx)
         REG_INVERT0: prdata = CsrDataWidth'(invert_ff[0]);
         REG_INVERT1: prdata = CsrDataWidth'(invert_ff[1]);
         REG_INVERT2: prdata = CsrDataWidth'(invert_ff[2]);
         REG_INVERT3: prdata = CsrDataWidth'(invert_ff[3]);
         REG_PERM0:   prdata = CsrDataWidth'(perm_ff[0]);
         REG_PERM1:   prdata = CsrDataWidth'(perm_ff[1]);
         REG_PERM2:   prdata = CsrDataWidth'(perm_ff[2]);
         REG_PERM3:   prdata = CsrDataWidth'(perm_ff[3]);
         default:     prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
   import bod_pkg::*;

   localparam int unsigned NumProbes     = 24;
   localparam int unsigned NumSegments   = 6;
   localparam int unsigned BeatsPerSeg   = 100;
   localparam int unsigned SettleCycles  = 4;
   localparam int unsigned WatchdogLimit = 2000;

   // one input beat, with its result typed in where it is obvious
   typedef struct packed {
      cmd_type  cmd;
      addr_type addr;
      byte_type raw;
      logic     known;
      byte_type data;
      bank_type bank;
   } probe_row_type;

   typedef struct packed {
      byte_type data;
      bank_type bank;
   } decoded_beat_type;

   // walk from reset: counter 10, bank 2
   localparam probe_row_type ProbeRows [NumProbes] = '{
      '{CMD_FETCH,     15'h0000, 8'h7D, 1'b1, 8'h00, 2'd2},
      '{CMD_FETCH,     15'h7FFF, 8'h82, 1'b1, 8'hFF, 2'd2},
      '{CMD_PORT_READ, 15'h0000, 8'hFF, 1'b1, 8'h00, 2'd3},
      '{CMD_FETCH,     15'h4000, 8'h77, 1'b1, 8'h00, 2'd3},
      '{CMD_PORT_READ, 15'h7FFF, 8'h00, 1'b1, 8'h00, 2'd2},
      '{CMD_PORT_READ, 15'h0001, 8'hA5, 1'b1, 8'h00, 2'd1},
      '{CMD_PORT_READ, 15'h7FFD, 8'h5A, 1'b1, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h3FFF, 8'hFC, 1'b1, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h0001, 8'h03, 1'b1, 8'hFF, 2'd0},
      '{CMD_PORT_READ, 15'h0001, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0003, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0005, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0007, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0009, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h000B, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h000D, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h000F, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0011, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h0002, 8'h00, 1'b1, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h0000, 8'h00, 1'b0, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h7FFF, 8'hFF, 1'b0, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h4000, 8'hA5, 1'b0, 8'h00, 2'd0},
      '{CMD_PORT_READ, 15'h7FFE, 8'h55, 1'b1, 8'h00, 2'd0},
      '{CMD_FETCH,     15'h2AAA, 8'h5A, 1'b0, 8'h00, 2'd0}
   };

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   csr_addr_type paddr;
   csr_data_type pwdata;
   csr_data_type prdata;
   logic pready;

   bod_req_if req_bus ();
   bod_rsp_if rsp_bus ();

   banked_opcode_decrypt_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // decoder shadow state
   byte_type  invert_mask [NumBanks];
   perm_type  perm_map [NumBanks];
   count_type step_count;
   bank_type  active_bank;

   decoded_beat_type plain_due [$];
   decoded_beat_type plain_head;
   int error_count;
   int quiet_cycles;
   int req_gap_pct;
   int rsp_stall_pct;

   always #5 clock = ~clock;

   // unscramble one byte: XOR with the mask, then route each output bit
   function automatic byte_type unscramble(input byte_type raw, input byte_type mask,
                                           input perm_type map);
      byte_type    mixed;
      byte_type    plain;
      int unsigned src;
      mixed = raw ^ mask;
      plain = '0;
      for (int k = 0; k < ByteWidth; k++) begin
         src = (map >> (3 * k)) & 7;
         plain[k] = mixed[src];
      end
      return plain;
   endfunction

   // advance the shadow state by one beat and return its result
   function automatic decoded_beat_type decode_beat(input cmd_type cmd, input addr_type addr,
                                                    input byte_type raw);
      decoded_beat_type beat;
      beat.data = '0;
      if (cmd == CMD_PORT_READ) begin
         if (addr[0]) step_count = step_count - 1'b1;
         else step_count = step_count + 1'b1;
         if (step_count[3:2] == BankWindow) active_bank = step_count[1:0];
      end else begin
         beat.data = unscramble(raw, invert_mask[active_bank], perm_map[active_bank]);
      end
      beat.bank = active_bank;
      return beat;
   endfunction

   // send one beat after a random gap and record what it should yield
   task automatic send_beat(input probe_row_type row);
      decoded_beat_type due;
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= row.cmd;
      req_bus.address  <= row.addr;
      req_bus.raw_byte <= row.raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      due = decode_beat(row.cmd, row.addr, row.raw);
      if (row.known) begin
         due.data = row.data;
         due.bank = row.bank;
      end
      plain_due.push_back(due);
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (plain_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // two-phase register write; psel stays up for back-to-back writes
   task automatic csr_write(input reg_idx_type idx, input csr_data_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx <= REG_INVERT3) invert_mask[idx[1:0]] = value[ByteWidth-1:0];
      else perm_map[idx[1:0]] = value[PermWidth-1:0];
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // load all masks and permutations for one segment
   task automatic apply_setting(input int unsigned seg);
      csr_data_type mask;
      csr_data_type map;
      for (int b = 0; b < NumBanks; b++) begin
         case (seg)
            0: begin
               mask = '0;
               map  = '0;
            end
            1: begin
               mask = '1;
               map  = '1;
            end
            3: begin
               mask = $urandom;
               map  = 32'h00FA_C688;
            end
            default: begin
               mask = $urandom;
               map  = $urandom;
            end
         endcase
         csr_write(reg_idx_type'(REG_INVERT0 + b), mask);
         csr_write(reg_idx_type'(REG_PERM0 + b), map);
      end
      csr_release();
   endtask

   // random beat; port reads mostly follow a drifting direction
   task automatic send_random(inout logic walk_down);
      probe_row_type row;
      row.cmd   = $urandom_range(1) ? CMD_FETCH : CMD_PORT_READ;
      row.addr  = addr_type'($urandom);
      row.raw   = byte_type'($urandom);
      row.known = 1'b0;
      row.data  = '0;
      row.bank  = '0;
      if (row.cmd == CMD_PORT_READ && $urandom_range(9) < 8) row.addr[0] = walk_down;
      if ($urandom_range(15) == 0) walk_down = ~walk_down;
      send_beat(row);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (plain_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result expected none got data %h bank %0d",
                     $time, rsp_bus.data, rsp_bus.bank);
         end else begin
            plain_head = plain_due.pop_front();
            if (rsp_bus.data !== plain_head.data) begin
               error_count++;
               $display("%0t: data expected %h got %h", $time, plain_head.data, rsp_bus.data);
            end
            if (rsp_bus.bank !== plain_head.bank) begin
               error_count++;
               $display("%0t: bank expected %0d got %0d", $time, plain_head.bank,
                        rsp_bus.bank);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic walk_down;
      clock            = 1'b0;
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_PORT_READ;
      req_bus.address  = '0;
      req_bus.raw_byte = '0;
      rsp_bus.ready    = 1'b0;
      error_count      = 0;
      quiet_cycles     = 0;
      req_gap_pct      = 35;
      rsp_stall_pct    = 60;
      walk_down        = 1'b0;
      invert_mask      = '{InvertReset0, InvertReset1, InvertReset2, InvertReset3};
      perm_map         = '{PermReset0, PermReset1, PermReset2, PermReset3};
      step_count       = CountReset;
      active_bank      = BankReset;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed walk under reset settings
      for (int i = 0; i < NumProbes; i++) send_beat(ProbeRows[i]);

      // random segments; idling mode changes every two segments
      for (int seg = 0; seg < NumSegments; seg++) begin
         case (seg / 2)
            0: begin
               req_gap_pct   = 35;
               rsp_stall_pct = 60;
            end
            1: begin
               req_gap_pct   = 60;
               rsp_stall_pct = 35;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         settle();
         apply_setting(seg);
         for (int n = 0; n < BeatsPerSeg; n++) send_random(walk_down);
      end

      settle();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
